>>> rtl/core/aob_pkg.sv
// Package for the ARGB over-blend unit: widths, pipeline stage types and the
// divider step function. No dependencies.
package aob_pkg;

    localparam int CH_W       = 8;
    localparam int NCH        = 3;
    localparam int PROD_W     = 2 * CH_W;
    localparam int WPROD_W    = 3 * CH_W;
    localparam int NUM_W      = PROD_W + 1;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = CH_W / DIV_STEPS;
    localparam int N_STAGES   = 3 + DIV_STAGES;

    localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

    typedef logic [CH_W-1:0] t_ch;
    typedef logic [NCH-1:0][CH_W-1:0] t_rgb;

    typedef struct packed {
        logic                          pass;
        t_ch                           src_a;
        t_rgb                          src_rgb;
        t_ch                           inv_a;
        logic [PROD_W-1:0]             wt;
        logic [NCH-1:0][PROD_W-1:0]    sp;
        logic [NCH-1:0][PROD_W-1:0]    dp;
    } t_s1;

    typedef struct packed {
        logic                          pass;
        t_ch                           src_a;
        t_rgb                          src_rgb;
        t_ch                           oa;
        logic [NCH-1:0][PROD_W-1:0]    sp;
        logic [NCH-1:0][WPROD_W-1:0]   dpw;
    } t_s2;

    typedef struct packed {
        logic                          pass;
        t_ch                           src_a;
        t_rgb                          src_rgb;
        t_ch                           oa;
        logic [NCH-1:0][NUM_W-1:0]     num;
    } t_s3;

    typedef struct packed {
        logic sat;
        t_ch  rem;
        t_ch  low;
        t_ch  quo;
    } t_lane;

    typedef struct packed {
        logic                pass;
        logic                zero;
        t_ch                 src_a;
        t_rgb                src_rgb;
        t_ch                 oa;
        t_lane [NCH-1:0]     lane;
    } t_div;

    // Runs DIV_STEPS restoring division steps on one channel.
    function automatic t_lane div_lane_stage(t_lane l, t_ch oa);
        t_lane         r;
        logic [CH_W:0] r9;
        r = l;
        for (int i = 0; i < DIV_STEPS; i++) begin
            r9    = {r.rem, r.low[CH_W-1]};
            r.low = {r.low[CH_W-2:0], 1'b0};
            if (r9 >= {1'b0, oa}) begin
                r.rem = CH_W'(r9 - {1'b0, oa});
                r.quo = {r.quo[CH_W-2:0], 1'b1};
            end else begin
                r.rem = r9[CH_W-1:0];
                r.quo = {r.quo[CH_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/core/aob_if.sv
// Handshake interfaces for the ARGB over-blend unit: source/destination pixel
// pair in, composited pixel out. Depends on aob_pkg.
interface aob_pix_if import aob_pkg::*; ();
    logic valid;
    logic ready;
    t_ch  src_alpha;
    t_ch  src_red;
    t_ch  src_green;
    t_ch  src_blue;
    t_ch  dst_alpha;
    t_ch  dst_red;
    t_ch  dst_green;
    t_ch  dst_blue;

    modport source (
        output valid, src_alpha, src_red, src_green, src_blue,
        output dst_alpha, dst_red, dst_green, dst_blue,
        input  ready
    );
    modport sink (
        input  valid, src_alpha, src_red, src_green, src_blue,
        input  dst_alpha, dst_red, dst_green, dst_blue,
        output ready
    );
endinterface

interface aob_res_if import aob_pkg::*; ();
    logic valid;
    logic ready;
    t_ch  out_alpha;
    t_ch  out_red;
    t_ch  out_green;
    t_ch  out_blue;

    modport source (
        output valid, out_alpha, out_red, out_green, out_blue,
        input  ready
    );
    modport sink (
        input  valid, out_alpha, out_red, out_green, out_blue,
        output ready
    );
endinterface

>>> rtl/core/argb_alpha_over_blend_unit.sv
// A pixel accepted on i_pix passes r_s1, r_s2, r_s3 and r_d on its way to o_res.
// Throughput: one pixel per cycle; the seven-stage pipeline (three multiply
// and add stages, four radix-2 divider stages of two steps each) stalls as a
// whole while the output transaction waits.
// Reset clears only the stage valid bits. Depends on aob_pkg and aob_if.
module argb_alpha_over_blend_unit import aob_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    aob_pix_if.sink      i_pix,
    aob_res_if.source    o_res
);

    logic [N_STAGES-1:0]   r_vld;
    logic [N_STAGES-1:0]   n_vld;
    logic                  en;

    t_s1                   r_s1, n_s1;
    t_s2                   r_s2, n_s2;
    t_s3                   r_s3, n_s3;
    t_div [DIV_STAGES-1:0] r_d,  n_d;

    logic [NUM_W-1:0]      wt_rnd;
    logic [CH_W:0]         dw;
    logic [CH_W+1:0]       oa_sum;
    t_rgb                  src_in;
    t_rgb                  dst_in;
    t_div                  d_init;
    t_div                  d_last;

    assign en          = !r_vld[N_STAGES-1] || o_res.ready;
    assign i_pix.ready = en;
    assign n_vld       = {r_vld[N_STAGES-2:0], i_pix.valid};

    assign src_in = {i_pix.src_blue, i_pix.src_green, i_pix.src_red};
    assign dst_in = {i_pix.dst_blue, i_pix.dst_green, i_pix.dst_red};

    always_comb begin
        n_s1.pass    = (i_pix.dst_alpha == '0);
        n_s1.src_a   = i_pix.src_alpha;
        n_s1.src_rgb = src_in;
        n_s1.inv_a   = CH_MAX - i_pix.src_alpha;
        n_s1.wt      = PROD_W'(i_pix.dst_alpha) * PROD_W'(CH_MAX - i_pix.src_alpha);
        for (int c = 0; c < NCH; c++) begin
            n_s1.sp[c] = PROD_W'(src_in[c]) * PROD_W'(i_pix.src_alpha);
            n_s1.dp[c] = PROD_W'(dst_in[c]) * PROD_W'(i_pix.dst_alpha);
        end
    end

    always_comb begin
        wt_rnd       = {1'b0, r_s1.wt} + NUM_W'(CH_MAX);
        dw           = wt_rnd[NUM_W-1:CH_W];
        oa_sum       = {2'b00, r_s1.src_a} + {1'b0, dw};
        n_s2.pass    = r_s1.pass;
        n_s2.src_a   = r_s1.src_a;
        n_s2.src_rgb = r_s1.src_rgb;
        n_s2.oa      = (oa_sum > {2'b00, CH_MAX}) ? CH_MAX : oa_sum[CH_W-1:0];
        n_s2.sp      = r_s1.sp;
        for (int c = 0; c < NCH; c++) begin
            n_s2.dpw[c] = WPROD_W'(r_s1.dp[c]) * WPROD_W'(r_s1.inv_a);
        end
    end

    always_comb begin
        n_s3.pass    = r_s2.pass;
        n_s3.src_a   = r_s2.src_a;
        n_s3.src_rgb = r_s2.src_rgb;
        n_s3.oa      = r_s2.oa;
        for (int c = 0; c < NCH; c++) begin
            n_s3.num[c] = NUM_W'({1'b0, r_s2.sp[c]}
                        + NUM_W'(({1'b0, r_s2.dpw[c]} + (WPROD_W+1)'(CH_MAX)) >> CH_W));
        end
    end

    always_comb begin
        d_init.pass    = r_s3.pass;
        d_init.zero    = (r_s3.oa == '0);
        d_init.src_a   = r_s3.src_a;
        d_init.src_rgb = r_s3.src_rgb;
        d_init.oa      = r_s3.oa;
        for (int c = 0; c < NCH; c++) begin
            d_init.lane[c].sat = (r_s3.num[c][NUM_W-1:CH_W] >= {1'b0, r_s3.oa});
            d_init.lane[c].rem = r_s3.num[c][PROD_W-1:CH_W];
            d_init.lane[c].low = r_s3.num[c][CH_W-1:0];
            d_init.lane[c].quo = '0;
        end
        for (int k = 0; k < DIV_STAGES; k++) begin
            n_d[k] = (k == 0) ? d_init : r_d[(k == 0) ? 0 : k - 1];
            for (int c = 0; c < NCH; c++) begin
                n_d[k].lane[c] = div_lane_stage(n_d[k].lane[c], n_d[k].oa);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_d  <= n_d;
        end
    end

    assign d_last      = r_d[DIV_STAGES-1];
    assign o_res.valid = r_vld[N_STAGES-1];

    always_comb begin
        if (d_last.pass) begin
            o_res.out_alpha = d_last.src_a;
            o_res.out_red   = d_last.src_rgb[0];
            o_res.out_green = d_last.src_rgb[1];
            o_res.out_blue  = d_last.src_rgb[2];
        end else if (d_last.zero) begin
            o_res.out_alpha = '0;
            o_res.out_red   = '0;
            o_res.out_green = '0;
            o_res.out_blue  = '0;
        end else begin
            o_res.out_alpha = d_last.oa;
            o_res.out_red   = d_last.lane[0].sat ? CH_MAX : d_last.lane[0].quo;
            o_res.out_green = d_last.lane[1].sat ? CH_MAX : d_last.lane[1].quo;
            o_res.out_blue  = d_last.lane[2].sat ? CH_MAX : d_last.lane[2].quo;
        end
    end

    a_oa_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] && !r_s3.pass |-> r_s3.oa != '0)
        else $error("Output alpha is zero for a non-empty destination.");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[N_STAGES-1] && !d_last.pass && !d_last.lane[0].sat
        |-> d_last.lane[0].rem < d_last.oa)
        else $error("Divider remainder is not below the divisor.");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[1] |=> r_vld[2])
        else $error("A transaction was lost between pipeline stages.");

endmodule
